/* rtl/bcc_pkg.sv */
package bcc_pkg;

  localparam int IN_W   = 7;
  localparam int WAYS_W = 63;

  typedef logic [IN_W-1:0]   field_t;
  typedef logic [WAYS_W-1:0] ways_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_ROW,
    ST_DRAIN,
    ST_READ,
    ST_OUT
  } state_t;

endpackage

/* rtl/bounded_composition_counter_unit.sv */
// Bounded composition counter.
// Counts the ordered ways to write in_total as a sum of exactly in_parts
// parts, each part between 1 and in_max_part. Zero into zero parts is one way.
// Input channel: a transaction is taken at a rising edge with start high and
// busy low; in_total, in_parts and in_max_part are sampled at that edge.
// Result channel: out_valid is high for exactly one cycle with out_ways; the
// receiver cannot stall, so the result must be taken in that cycle.
// The count is built row by row in a two-row memory (2*(MAX_TOTAL+1) words)
// with one write and two reads per cycle; each row is a sliding window sum
// over the previous row, one cell per cycle.
// A query with total above MAX_TOTAL or more parts than total skips the row
// work and answers with a zero count.
// One query is worked on at a time; busy stays high until the result cycle,
// so the next transaction can be taken while out_valid is shown.
// Reset (synchronous, active low) returns the controller to idle and drops
// any result in flight; the row memory keeps no reset and every entry a
// query reads is written earlier by that same query.
module bounded_composition_counter_unit #(
  parameter int MAX_TOTAL = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  bcc_pkg::field_t in_total,
  input  bcc_pkg::field_t in_parts,
  input  bcc_pkg::field_t in_max_part,
  output logic           out_valid,
  output bcc_pkg::ways_t out_ways
);
  import bcc_pkg::*;

  localparam int ROW_LEN = MAX_TOTAL + 1;
  localparam int DEPTH   = 2 * ROW_LEN;
  localparam int AW      = $clog2(DEPTH);
  localparam int JW      = $clog2(ROW_LEN);

  // Query and loop control
  state_t         state_r, state_nxt;
  logic [JW-1:0]  t_r, t_nxt;
  logic [JW-1:0]  p_r, p_nxt;
  field_t         m_r, m_nxt;
  logic [JW-1:0]  j_r, j_nxt;
  logic [JW-1:0]  k_r, k_nxt;
  logic           sel_r, sel_nxt;
  logic           zero_r, zero_nxt;

  // Window pipeline stage (read issued last cycle, write this cycle)
  logic           v_r, v_nxt;
  logic [JW-1:0]  jd_r, jd_nxt;
  logic           sub_r, sub_nxt;
  ways_t          win_r, win_nxt;

  // Result register
  logic           out_valid_r, out_valid_nxt;
  ways_t          out_ways_r, out_ways_nxt;

  // Row memory ports
  ways_t          mem [DEPTH];
  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  ways_t          wr_data;
  logic [AW-1:0]  rd_addr_a, rd_addr_b;
  ways_t          rd_a_r, rd_b_r;

  logic [AW-1:0]  base_prev, base_cur;
  logic [JW-1:0]  m_low;
  logic           reject;

  assign base_prev = sel_r ? AW'(ROW_LEN) : '0;
  assign base_cur  = sel_r ? '0 : AW'(ROW_LEN);
  assign m_low     = JW'(m_r);
  assign reject    = (in_total > IN_W'(MAX_TOTAL)) || (in_parts > in_total);

  // Window sum of the cell whose reads came back this cycle
  assign win_nxt = win_r + rd_a_r - (sub_r ? rd_b_r : '0);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a_r <= mem[rd_addr_a];
    rd_b_r <= mem[rd_addr_b];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      v_r         <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      v_r         <= v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r        <= t_nxt;
    p_r        <= p_nxt;
    m_r        <= m_nxt;
    j_r        <= j_nxt;
    k_r        <= k_nxt;
    sel_r      <= sel_nxt;
    zero_r     <= zero_nxt;
    jd_r       <= jd_nxt;
    sub_r      <= sub_nxt;
    out_ways_r <= out_ways_nxt;
    if (state_r == ST_ROW && j_r == '0) begin
      win_r <= '0;
    end else if (v_r) begin
      win_r <= win_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    t_nxt         = t_r;
    p_nxt         = p_r;
    m_nxt         = m_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    sel_nxt       = sel_r;
    zero_nxt      = zero_r;
    v_nxt         = 1'b0;
    jd_nxt        = j_r;
    sub_nxt       = IN_W'(j_r) > m_r;
    out_valid_nxt = 1'b0;
    out_ways_nxt  = out_ways_r;
    wr_en         = 1'b0;
    wr_addr       = base_prev + AW'(j_r);
    wr_data       = '0;
    // Cell j reads prev[j-1] and, once the window is full, prev[j-1-m]
    rd_addr_a     = base_prev + AW'(j_r - JW'(1));
    rd_addr_b     = base_prev + AW'(j_r - JW'(1) - m_low);

    // A pending window result always lands in the current row
    if (v_r) begin
      wr_en   = 1'b1;
      wr_addr = base_cur + AW'(jd_r);
      wr_data = win_nxt;
    end

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          t_nxt    = JW'(in_total);
          p_nxt    = JW'(in_parts);
          m_nxt    = in_max_part;
          j_nxt    = '0;
          k_nxt    = JW'(1);
          sel_nxt  = 1'b0;
          zero_nxt = reject;
          state_nxt = reject ? ST_OUT : ST_INIT;
        end
      end
      ST_INIT: begin
        // Row zero: only value zero is reachable with no parts
        wr_en   = 1'b1;
        wr_addr = base_prev + AW'(j_r);
        wr_data = (j_r == '0) ? ways_t'(1) : '0;
        if (j_r == t_r) begin
          j_nxt     = '0;
          state_nxt = (p_r == '0) ? ST_READ : ST_ROW;
        end else begin
          j_nxt = j_r + JW'(1);
        end
      end
      ST_ROW: begin
        if (j_r == '0) begin
          wr_en   = 1'b1;
          wr_addr = base_cur;
          wr_data = '0;
          j_nxt   = JW'(1);
        end else begin
          v_nxt = 1'b1;
          if (j_r == t_r) begin
            state_nxt = ST_DRAIN;
          end else begin
            j_nxt = j_r + JW'(1);
          end
        end
      end
      ST_DRAIN: begin
        // Last cell lands this cycle; swap rows
        sel_nxt = ~sel_r;
        j_nxt   = '0;
        if (k_r == p_r) begin
          state_nxt = ST_READ;
        end else begin
          k_nxt     = k_r + JW'(1);
          state_nxt = ST_ROW;
        end
      end
      ST_READ: begin
        rd_addr_a = base_prev + AW'(t_r);
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        out_valid_nxt = 1'b1;
        out_ways_nxt  = zero_r ? '0 : rd_a_r;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_ways  = out_ways_r;

`ifndef SYNTHESIS
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe repeated");

  a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("transaction accepted without going busy");

  // The trailing read only matters once the window is full
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r && state_r == ST_ROW) |->
      (wr_addr != rd_addr_a && (!sub_nxt || wr_addr != rd_addr_b)))
    else $error("row write hits a location being read");

  a_result_after_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == ST_OUT))
    else $error("result strobe without a finished query");
`endif

endmodule

/* test/bounded_composition_counter_unit_tb.sv */
module bounded_composition_counter_unit_tb;
  import bcc_pkg::*;

  // Largest total the row memory can hold; must match the DUT parameter.
  localparam int MAX_TOTAL = 64;
  // Cycles with no transaction on either side before the run is abandoned.
  // The limit leaves several times the slowest legal quiet stretch, a full
  // 64 by 64 query followed by the longest sender gap.
  localparam int WATCHDOG_LIMIT = 20000;
  // Cycles to keep watching after the last result, to catch stray strobes.
  localparam int TAIL_CYCLES = 20;
  localparam int RANDOM_QUERIES = 120;

  typedef struct {
    field_t      total;
    field_t      parts;
    field_t      max_part;
    int unsigned gap;
  } query_t;

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   start = 1'b0;
  logic   busy;
  field_t in_total = '0;
  field_t in_parts = '0;
  field_t in_max_part = '0;
  logic   out_valid;
  ways_t  out_ways;

  query_t      pending_queries[$];
  ways_t       expected_ways[$];
  int unsigned query_count;
  int unsigned queries_sent = 0;
  int unsigned results_seen = 0;
  int unsigned rejected_queries = 0;
  int unsigned nonzero_counts = 0;
  int unsigned failures = 0;
  int unsigned idle_cycles = 0;
  int unsigned hold_off = 0;
  query_t      next_query;

  bounded_composition_counter_unit #(
    .MAX_TOTAL(MAX_TOTAL)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_total   (in_total),
    .in_parts   (in_parts),
    .in_max_part(in_max_part),
    .out_valid  (out_valid),
    .out_ways   (out_ways)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Count ordered compositions of total into exactly parts parts, each part
  // in 1..max_part. Build it one row per part: entry j of a row is the number
  // of ways to reach j, and each new entry is a running sum over the last
  // max_part entries of the previous row.
  function automatic ways_t count_compositions(field_t total, field_t parts,
                                               field_t max_part);
    logic [63:0] last_row [0:MAX_TOTAL];
    logic [63:0] this_row [0:MAX_TOTAL];
    logic [63:0] window;
    int          t;
    int          p;
    int          m;
    if (total > MAX_TOTAL || parts > total) return '0;
    t = total;
    p = parts;
    m = max_part;
    // With no parts only zero is reachable.
    for (int j = 0; j <= t; j++) last_row[j] = (j == 0) ? 64'd1 : 64'd0;
    for (int k = 1; k <= p; k++) begin
      window = '0;
      this_row[0] = '0;
      for (int j = 1; j <= t; j++) begin
        window = window + last_row[j-1];
        // Drop the entry that just slid out of the window.
        if (j >= m + 1) window = window - last_row[j-1-m];
        this_row[j] = {1'b0, window[WAYS_W-1:0]};
      end
      for (int j = 0; j <= t; j++) last_row[j] = this_row[j];
    end
    return last_row[t][WAYS_W-1:0];
  endfunction

  function automatic void add_query(int unsigned total, int unsigned parts,
                                    int unsigned max_part, int unsigned gap);
    query_t q;
    q.total    = field_t'(total);
    q.parts    = field_t'(parts);
    q.max_part = field_t'(max_part);
    q.gap      = gap;
    pending_queries.push_back(q);
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  // Driver: a transaction completes at an edge with start high and busy low.
  // On that edge record the prediction, then either hold off for the next
  // query's gap or present it right away so start stays high back to back.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      hold_off = 0;
    end else if (start && busy) begin
      // Hold the query until the block frees up.
    end else begin
      if (start) begin
        expected_ways.push_back(count_compositions(in_total, in_parts, in_max_part));
        if (in_total > MAX_TOTAL || in_parts > in_total) rejected_queries++;
        queries_sent++;
      end
      if (pending_queries.size() == 0) begin
        start <= 1'b0;
      end else if (hold_off < pending_queries[0].gap) begin
        hold_off++;
        start <= 1'b0;
      end else begin
        next_query = pending_queries.pop_front();
        hold_off = 0;
        in_total <= next_query.total;
        in_parts <= next_query.parts;
        in_max_part <= next_query.max_part;
        start <= 1'b1;
      end
    end
  end

  // Monitor: take every strobed result and check it against the oldest
  // prediction. Also track quiet cycles for the watchdog.
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else begin
      if (out_valid) begin
        results_seen++;
        if (expected_ways.size() == 0) begin
          $error("ways: result 0x%016h with no query outstanding", out_ways);
          failures++;
        end else begin
          if (out_ways !== expected_ways[0]) begin
            $error("ways: expected %0d, got %0d", expected_ways[0], out_ways);
            failures++;
          end
          if (expected_ways[0] != '0) nonzero_counts++;
          void'(expected_ways.pop_front());
        end
      end
      if (out_valid || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // Watchdog: end the run if the block goes quiet for too long.
  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("tb: failure");
    $finish;
  end

  // Stimulus and end of run.
  initial begin
    int unsigned r;
    int unsigned t;
    int unsigned gap;

    // Directed part: corners of each field and the special cases.
    add_query(0, 0, 1, 0);        // zero into zero parts
    add_query(0, 0, 0, 0);        // zero max part, empty split still counts
    add_query(5, 0, 0, 1);        // zero max part, nonzero total
    add_query(10, 3, 0, 0);       // zero max part with parts
    add_query(0, 1, 1, 0);        // more parts than the total
    add_query(64, 65, 64, 0);     // parts above the table size
    add_query(65, 1, 1, 2);       // total just above the table size
    add_query(127, 127, 127, 0);  // every field at its all-ones value
    add_query(127, 0, 1, 0);
    add_query(64, 64, 1, 0);      // all parts equal to one
    add_query(64, 1, 64, 0);      // single part equal to the total
    add_query(64, 2, 1, 0);       // max part too small to reach the total
    add_query(10, 3, 127, 0);     // max part above the total
    add_query(10, 3, 4, 0);
    add_query(1, 1, 1, 0);
    add_query(7, 7, 1, 0);
    add_query(20, 5, 3, 3);
    add_query(64, 10, 7, 0);
    add_query(63, 31, 64, 0);     // near the largest count
    add_query(64, 32, 64, 0);
    add_query(64, 64, 64, 0);     // longest query

    // Random part: mostly small, valid queries; some mid-sized and large
    // ones; the rest fully random fields that are mostly rejected.
    for (int i = 0; i < RANDOM_QUERIES; i++) begin
      // Run one stretch back to back with no idling at all.
      gap = (i >= 40 && i < 60) ? 0 : pick_gap();
      r = $urandom_range(0, 99);
      if (r < 60) begin
        t = $urandom_range(0, 16);
        add_query(t, $urandom_range(0, t), $urandom_range(1, t + 2), gap);
      end else if (r < 75) begin
        t = $urandom_range(0, 40);
        add_query(t, $urandom_range(0, t), $urandom_range(1, 64), gap);
      end else if (r < 82) begin
        t = $urandom_range(41, MAX_TOTAL);
        add_query(t, $urandom_range(0, t), $urandom_range(1, 64), gap);
      end else begin
        add_query($urandom_range(0, 127), $urandom_range(0, 127),
                  $urandom_range(0, 127), gap);
      end
    end
    query_count = pending_queries.size();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (queries_sent < query_count) @(posedge clk);
    while (expected_ways.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d queries, %0d rejected for range or too many parts,",
             queries_sent, rejected_queries);
    $display("%0d results checked, %0d with a nonzero count", results_seen,
             nonzero_counts);
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
